### hw/rtl/general_matrix_multiply_top_assert.svh
// ----------------------------------------------------------------------------
// gemm assertion macros
// concurrent assertion shorthands clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef GENERAL_MATRIX_MULTIPLY_TOP_ASSERT_SVH
`define GENERAL_MATRIX_MULTIPLY_TOP_ASSERT_SVH

// same-cycle implication
`define GMM_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define GMM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/gmm_pkg.sv
// ----------------------------------------------------------------------------
// gmm_pkg
// shared types, widths and codes of the gemm block
// ----------------------------------------------------------------------------
package gmm_pkg;

	localparam int MAX_DIM     = 8;
	localparam int DIM_W       = 4;
	localparam int ADDR_W      = 6;
	localparam int DATA_W      = 16;
	localparam int ADRP_W      = 2 * DIM_W;
	// exact sum of up to eight a*b products
	localparam int SUM_W       = 36;
	localparam int ACC_W       = SUM_W + DATA_W;
	localparam int RQ_W        = ACC_W - 16;
	localparam int REG_IDX_W   = 3;
	localparam int APB_ADDR_W  = REG_IDX_W + 2;
	localparam int APB_DATA_W  = 32;

	localparam logic [DIM_W-1:0]         RST_DIM   = DIM_W'(MAX_DIM);
	localparam logic signed [DATA_W-1:0] RST_ALPHA = 16'sd256;
	localparam logic signed [DATA_W-1:0] RST_BETA  = 16'sd0;

	typedef enum logic [1:0] {
		ACT_WR_A    = 2'd0,
		ACT_WR_B    = 2'd1,
		ACT_WR_C    = 2'd2,
		ACT_COMPUTE = 2'd3
	} action_t;

	localparam logic [REG_IDX_W-1:0] REG_TRANSPOSE_A = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_TRANSPOSE_B = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_ROWS_M      = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_COLS_N      = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_INNER_K     = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_ALPHA_GAIN  = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_BETA_GAIN   = 3'd6;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_AB,
		OP_ALPHA,
		OP_BETA
	} op_kind_t;

	typedef struct packed {
		logic                     transpose_a;
		logic                     transpose_b;
		logic [DIM_W-1:0]         rows_m;
		logic [DIM_W-1:0]         cols_n;
		logic [DIM_W-1:0]         inner_k;
		logic signed [DATA_W-1:0] alpha_gain;
		logic signed [DATA_W-1:0] beta_gain;
	} cfg_t;

	typedef struct packed {
		logic     issue;
		op_kind_t kind;
		logic     acc_clr;
		logic     emit;
	} mac_ctrl_t;

	typedef struct packed {
		logic pending;
	} mac_stat_t;

endpackage

### hw/rtl/gmm_ram.sv
// ----------------------------------------------------------------------------
// gmm_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module gmm_ram #(
	parameter  int WIDTH = 16,
	parameter  int DEPTH = 64,
	localparam int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### hw/rtl/gmm_mac.sv
// ----------------------------------------------------------------------------
// gmm_mac
// shared multiplier and accumulator with rounding and saturation
// ----------------------------------------------------------------------------
module gmm_mac import gmm_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cfg_t                     cfg,
	input  mac_ctrl_t                ctrl,
	input  logic signed [DATA_W-1:0] a_rdata,
	input  logic signed [DATA_W-1:0] b_rdata,
	input  logic signed [DATA_W-1:0] c_rdata,
	output mac_stat_t                stat,
	output logic signed [DATA_W-1:0] result,
	output logic signed [DATA_W-1:0] out_value
);

	localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(32768);
	localparam logic signed [RQ_W-1:0]  Q_MAX    = {{(RQ_W-16){1'b0}}, 16'h7FFF};
	localparam logic signed [RQ_W-1:0]  Q_MIN    = {{(RQ_W-16){1'b1}}, 16'h8000};

	logic                     v_s1, v_s2;
	op_kind_t                 kind_s1, kind_s2;
	logic signed [SUM_W-1:0]  opa;
	logic signed [DATA_W-1:0] opb;
	logic signed [ACC_W-1:0]  prod_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  rnd;
	logic signed [RQ_W-1:0]   rq;
	logic signed [DATA_W-1:0] out_value_q;

	// operand select, ram data is valid in stage 1
	always_comb begin
		case (kind_s1)
			OP_AB: begin
				opa = {{(SUM_W-DATA_W){a_rdata[DATA_W-1]}}, a_rdata};
				opb = b_rdata;
			end
			OP_ALPHA: begin
				opa = acc_q[SUM_W-1:0];
				opb = cfg.alpha_gain;
			end
			OP_BETA: begin
				opa = {{(SUM_W-DATA_W){c_rdata[DATA_W-1]}}, c_rdata};
				opb = cfg.beta_gain;
			end
			default: begin
				opa = '0;
				opb = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			kind_s1 <= OP_NONE;
			kind_s2 <= OP_NONE;
		end else begin
			v_s1    <= ctrl.issue;
			v_s2    <= v_s1;
			kind_s1 <= ctrl.kind;
			kind_s2 <= kind_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= opa * opb;
		if (ctrl.acc_clr) begin
			acc_q <= '0;
		end else if (v_s2) begin
			case (kind_s2)
				OP_AB:    acc_q <= acc_q + prod_s2;
				OP_ALPHA: acc_q <= prod_s2;
				OP_BETA:  acc_q <= acc_q + (prod_s2 <<< 8);
				default:  acc_q <= acc_q;
			endcase
		end
		if (ctrl.emit) begin
			out_value_q <= result;
		end
	end

	// round half up, drop 16 fraction bits, clamp to 16 bits
	always_comb begin
		rnd = acc_q + RND_HALF;
		rq  = rnd[ACC_W-1:16];
		if (rq > Q_MAX) begin
			result = 16'sh7FFF;
		end else if (rq < Q_MIN) begin
			result = 16'sh8000;
		end else begin
			result = rq[DATA_W-1:0];
		end
	end

	assign stat.pending = v_s1 | v_s2;
	assign out_value    = out_value_q;

endmodule

### hw/rtl/gmm_seq.sv
// ----------------------------------------------------------------------------
// gmm_seq
// sequencer walking rows, columns and the inner dimension
// ----------------------------------------------------------------------------
module gmm_seq import gmm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [1:0]        action,
	input  cfg_t              cfg,
	input  mac_stat_t         stat,
	output mac_ctrl_t         ctrl,
	output logic              busy,
	output logic [ADDR_W-1:0] a_raddr,
	output logic [ADDR_W-1:0] b_raddr,
	output logic [ADDR_W-1:0] c_addr,
	output logic              valid,
	output logic [ADDR_W-1:0] out_index,
	output logic              last
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ELEM,
		S_AB,
		S_DRAIN_AB,
		S_ALPHA,
		S_BETA,
		S_DRAIN_END,
		S_EMIT
	} state_t;

	state_t            state_q;
	logic [DIM_W-1:0]  i_q, j_q, t_q;
	logic [DIM_W-1:0]  m_q, n_q, k_q;
	logic              ta_q, tb_q;
	logic              valid_q, last_q;
	logic [ADDR_W-1:0] out_index_q;
	logic [DIM_W-1:0]  m_c, n_c, k_c;
	logic [ADRP_W-1:0] a_full, b_full, c_full;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
		return (d > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : d;
	endfunction

	assign m_c = clamp_dim(cfg.rows_m);
	assign n_c = clamp_dim(cfg.cols_n);
	assign k_c = clamp_dim(cfg.inner_k);

	// flat addresses, leading dimension follows the transpose flags
	always_comb begin
		a_full = ta_q ? (ADRP_W'(t_q) * ADRP_W'(m_q) + ADRP_W'(i_q))
		              : (ADRP_W'(i_q) * ADRP_W'(k_q) + ADRP_W'(t_q));
		b_full = tb_q ? (ADRP_W'(j_q) * ADRP_W'(k_q) + ADRP_W'(t_q))
		              : (ADRP_W'(t_q) * ADRP_W'(n_q) + ADRP_W'(j_q));
		c_full = ADRP_W'(i_q) * ADRP_W'(n_q) + ADRP_W'(j_q);
	end

	assign a_raddr = a_full[ADDR_W-1:0];
	assign b_raddr = b_full[ADDR_W-1:0];
	assign c_addr  = c_full[ADDR_W-1:0];

	always_comb begin
		ctrl.issue   = 1'b0;
		ctrl.kind    = OP_NONE;
		ctrl.acc_clr = (state_q == S_ELEM);
		ctrl.emit    = (state_q == S_EMIT);
		case (state_q)
			S_AB: begin
				ctrl.issue = 1'b1;
				ctrl.kind  = OP_AB;
			end
			S_ALPHA: begin
				ctrl.issue = 1'b1;
				ctrl.kind  = OP_ALPHA;
			end
			S_BETA: begin
				ctrl.issue = 1'b1;
				ctrl.kind  = OP_BETA;
			end
			default: begin
				ctrl.issue = 1'b0;
				ctrl.kind  = OP_NONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			i_q         <= '0;
			j_q         <= '0;
			t_q         <= '0;
			m_q         <= '0;
			n_q         <= '0;
			k_q         <= '0;
			ta_q        <= 1'b0;
			tb_q        <= 1'b0;
			valid_q     <= 1'b0;
			last_q      <= 1'b0;
			out_index_q <= '0;
		end else begin
			// strobe for exactly the cycle after an emit
			valid_q <= (state_q == S_EMIT);
			case (state_q)
				S_IDLE: begin
					if (start && action == ACT_COMPUTE) begin
						m_q  <= m_c;
						n_q  <= n_c;
						k_q  <= k_c;
						ta_q <= cfg.transpose_a;
						tb_q <= cfg.transpose_b;
						i_q  <= '0;
						j_q  <= '0;
						// an empty result matrix emits nothing
						if (m_c != '0 && n_c != '0) begin
							state_q <= S_ELEM;
						end
					end
				end
				S_ELEM: begin
					t_q     <= '0;
					state_q <= (k_q == '0) ? S_ALPHA : S_AB;
				end
				S_AB: begin
					if (t_q == k_q - DIM_W'(1)) begin
						state_q <= S_DRAIN_AB;
					end else begin
						t_q <= t_q + DIM_W'(1);
					end
				end
				S_DRAIN_AB: begin
					if (!stat.pending) begin
						state_q <= S_ALPHA;
					end
				end
				S_ALPHA: begin
					state_q <= S_BETA;
				end
				S_BETA: begin
					state_q <= S_DRAIN_END;
				end
				S_DRAIN_END: begin
					if (!stat.pending) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					out_index_q <= c_addr;
					last_q      <= (i_q == m_q - DIM_W'(1)) && (j_q == n_q - DIM_W'(1));
					if (j_q == n_q - DIM_W'(1)) begin
						j_q <= '0;
						if (i_q == m_q - DIM_W'(1)) begin
							state_q <= S_IDLE;
						end else begin
							i_q     <= i_q + DIM_W'(1);
							state_q <= S_ELEM;
						end
					end else begin
						j_q     <= j_q + DIM_W'(1);
						state_q <= S_ELEM;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy      = (state_q != S_IDLE);
	assign valid     = valid_q;
	assign out_index = out_index_q;
	assign last      = last_q;

endmodule

### hw/rtl/general_matrix_multiply_top.sv
// load transaction: one per cycle while the block is idle, busy stays low,
// the element is stored at the accepting edge
// compute transaction: M*N C elements in row-major order, busy high until the last element
// element rate set by the single shared multiplier and its read/multiply/accumulate drain
// reset: config registers to defaults, sequencer idle; matrix stores are not cleared
// ----------------------------------------------------------------------------
// general_matrix_multiply_top
// gemm block, C = beta*C + alpha*op(A)*op(B) on signed q8.8 element stores
// ----------------------------------------------------------------------------
module general_matrix_multiply_top import gmm_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	// command channel
	input  logic                     start,
	output logic                     busy,
	input  logic [1:0]               action,
	input  logic [ADDR_W-1:0]        index,
	input  logic signed [DATA_W-1:0] value,
	// result channel
	output logic                     valid,
	output logic [ADDR_W-1:0]        out_index,
	output logic signed [DATA_W-1:0] out_value,
	output logic                     last,
	// register port
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_ADDR_W-1:0]    paddr,
	input  logic [APB_DATA_W-1:0]    pwdata,
	output logic [APB_DATA_W-1:0]    prdata,
	output logic                     pready
);

	cfg_t                     cfg_q;
	logic                     cfg_wr;
	logic [REG_IDX_W-1:0]     reg_idx;
	logic                     load_ok;
	logic                     we_a, we_b, we_c_load;
	mac_ctrl_t                ctrl;
	mac_stat_t                stat;
	logic [ADDR_W-1:0]        a_raddr, b_raddr, c_addr;
	logic [DATA_W-1:0]        a_rdata, b_rdata, c_rdata;
	logic signed [DATA_W-1:0] result;
	logic                     c_we;
	logic [ADDR_W-1:0]        c_waddr;
	logic [DATA_W-1:0]        c_wdata;

	// register port, zero wait states
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = paddr[APB_ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.transpose_a <= 1'b0;
			cfg_q.transpose_b <= 1'b0;
			cfg_q.rows_m      <= RST_DIM;
			cfg_q.cols_n      <= RST_DIM;
			cfg_q.inner_k     <= RST_DIM;
			cfg_q.alpha_gain  <= RST_ALPHA;
			cfg_q.beta_gain   <= RST_BETA;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_TRANSPOSE_A: cfg_q.transpose_a <= pwdata[0];
				REG_TRANSPOSE_B: cfg_q.transpose_b <= pwdata[0];
				REG_ROWS_M:      cfg_q.rows_m      <= pwdata[DIM_W-1:0];
				REG_COLS_N:      cfg_q.cols_n      <= pwdata[DIM_W-1:0];
				REG_INNER_K:     cfg_q.inner_k     <= pwdata[DIM_W-1:0];
				REG_ALPHA_GAIN:  cfg_q.alpha_gain  <= pwdata[DATA_W-1:0];
				REG_BETA_GAIN:   cfg_q.beta_gain   <= pwdata[DATA_W-1:0];
				default: ;
			endcase
		end
	end

	// read back, unused addresses return zero
	always_comb begin
		case (reg_idx)
			REG_TRANSPOSE_A: prdata = {31'b0, cfg_q.transpose_a};
			REG_TRANSPOSE_B: prdata = {31'b0, cfg_q.transpose_b};
			REG_ROWS_M:      prdata = {{(APB_DATA_W-DIM_W){1'b0}}, cfg_q.rows_m};
			REG_COLS_N:      prdata = {{(APB_DATA_W-DIM_W){1'b0}}, cfg_q.cols_n};
			REG_INNER_K:     prdata = {{(APB_DATA_W-DIM_W){1'b0}}, cfg_q.inner_k};
			REG_ALPHA_GAIN:  prdata = {{(APB_DATA_W-DATA_W){1'b0}}, cfg_q.alpha_gain};
			REG_BETA_GAIN:   prdata = {{(APB_DATA_W-DATA_W){1'b0}}, cfg_q.beta_gain};
			default:         prdata = '0;
		endcase
	end

	// load transactions go straight into the stores
	assign load_ok   = start && !busy;
	assign we_a      = load_ok && (action == ACT_WR_A);
	assign we_b      = load_ok && (action == ACT_WR_B);
	assign we_c_load = load_ok && (action == ACT_WR_C);

	// c store shared between loads and write-back; write-back only while busy
	assign c_we    = we_c_load || ctrl.emit;
	assign c_waddr = ctrl.emit ? c_addr : index;
	assign c_wdata = ctrl.emit ? result : value;

	gmm_ram #(.WIDTH(DATA_W), .DEPTH(MAX_DIM * MAX_DIM)) u_a_ram (
		.clk   (clk),
		.we    (we_a),
		.waddr (index),
		.wdata (value),
		.raddr (a_raddr),
		.rdata (a_rdata)
	);

	gmm_ram #(.WIDTH(DATA_W), .DEPTH(MAX_DIM * MAX_DIM)) u_b_ram (
		.clk   (clk),
		.we    (we_b),
		.waddr (index),
		.wdata (value),
		.raddr (b_raddr),
		.rdata (b_rdata)
	);

	gmm_ram #(.WIDTH(DATA_W), .DEPTH(MAX_DIM * MAX_DIM)) u_c_ram (
		.clk   (clk),
		.we    (c_we),
		.waddr (c_waddr),
		.wdata (c_wdata),
		.raddr (c_addr),
		.rdata (c_rdata)
	);

	// sequencer: element loop, inner loop and result strobe
	gmm_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.action    (action),
		.cfg       (cfg_q),
		.stat      (stat),
		.ctrl      (ctrl),
		.busy      (busy),
		.a_raddr   (a_raddr),
		.b_raddr   (b_raddr),
		.c_addr    (c_addr),
		.valid     (valid),
		.out_index (out_index),
		.last      (last)
	);

	// shared multiplier: a*b terms, then alpha scale, then beta*c
	gmm_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.ctrl      (ctrl),
		.a_rdata   (a_rdata),
		.b_rdata   (b_rdata),
		.c_rdata   (c_rdata),
		.stat      (stat),
		.result    (result),
		.out_value (out_value)
	);

endmodule

### hw/rtl/gmm_checker.sv
// ----------------------------------------------------------------------------
// gmm_checker
// port-level assertions on the gemm top, attached by bind
// ----------------------------------------------------------------------------
`include "general_matrix_multiply_top_assert.svh"

module gmm_checker import gmm_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [1:0] action,
	input logic       valid,
	input logic       last
);

	// results only come out of a running compute
	`GMM_ASSERT_SAME(a_valid_after_busy, valid, $past(busy), "result strobe without compute")
	// the final element ends the compute
	`GMM_ASSERT_SAME(a_last_idle, valid && last, !busy, "busy after final element")
	// more elements still to come
	`GMM_ASSERT_SAME(a_mid_busy, valid && !last, busy, "idle before final element")
	// load transactions never start a compute
	`GMM_ASSERT_NEXT(a_load_idle, start && !busy && action != ACT_COMPUTE, !busy, "busy after load")

endmodule

bind general_matrix_multiply_top gmm_checker u_gmm_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.action (action),
	.valid  (valid),
	.last   (last)
);

### tb/sv/general_matrix_multiply_top_tb.sv
// ----------------------------------------------------------------------------
// general_matrix_multiply_top_tb
// self-checking bench for the gemm block: fills the three element stores,
// walks a table of corner cases, then runs randomised phases of loads and
// computes under changing register settings and sender idling; every emitted
// c element is compared with an in-bench model of the block
// ----------------------------------------------------------------------------
module general_matrix_multiply_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import gmm_pkg::*;

	localparam int CLK_PERIOD   = 20;
	localparam int RESET_CYCLES = 5;
	// long enough for the longest element, so this covers a compute still draining
	localparam int QUIET_CYCLES = 32;
	localparam int RANDOM_ITEMS = 190;
	localparam int STORE_DEPTH  = MAX_DIM * MAX_DIM;
	localparam int TIMEOUT_NS   = 60_000_000;
	localparam int IDLE_NONE    = 0;
	localparam int IDLE_HEAVY   = 82;
	localparam int IDLE_LIGHT   = 8;
	// beyond the last register, writes to it must be dropped
	localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;

	// one emitted c element
	typedef struct {
		logic [ADDR_W-1:0]        pos;
		logic signed [DATA_W-1:0] val;
		logic                     last;
	} c_elem_t;

	// one row of the directed table: a register write or a command transaction
	typedef struct {
		bit                       is_cfg;
		logic [REG_IDX_W-1:0]     reg_idx;
		logic [31:0]              reg_val;
		action_t                  act;
		logic [ADDR_W-1:0]        pos;
		logic signed [DATA_W-1:0] val;
		bit                       typed;
		logic signed [DATA_W-1:0] typed_val;
	} stim_row_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start = 1'b0;
	logic                     busy;
	logic [1:0]               action = ACT_WR_A;
	logic [ADDR_W-1:0]        index = '0;
	logic signed [DATA_W-1:0] value = '0;
	logic                     valid;
	logic [ADDR_W-1:0]        out_index;
	logic signed [DATA_W-1:0] out_value;
	logic                     last;
	logic                     psel = 1'b0;
	logic                     penable = 1'b0;
	logic                     pwrite = 1'b0;
	logic [APB_ADDR_W-1:0]    paddr = '0;
	logic [APB_DATA_W-1:0]    pwdata = '0;
	logic [APB_DATA_W-1:0]    prdata;
	logic                     pready;

	// model state: element stores and register copy
	logic signed [DATA_W-1:0] a_mem [STORE_DEPTH];
	logic signed [DATA_W-1:0] b_mem [STORE_DEPTH];
	logic signed [DATA_W-1:0] c_mem [STORE_DEPTH];
	cfg_t                     cfg_shadow;

	c_elem_t   c_expect_q [$];
	stim_row_t dir_rows [$];
	int        mismatch_count = 0;
	int        items_sent = 0;
	int        idle_pct = IDLE_NONE;
	bit        settle_needed = 1'b0;

	general_matrix_multiply_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.action    (action),
		.index     (index),
		.value     (value),
		.valid     (valid),
		.out_index (out_index),
		.out_value (out_value),
		.last      (last),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// hard stop in case the block hangs or an expected element never shows
	initial begin
		#TIMEOUT_NS;
		$display("[general_matrix_multiply_top] ERROR");
		$finish;
	end

	// ------------------------------------------------------------------------
	// model of the block
	// ------------------------------------------------------------------------

	// dimensions above MAX_DIM saturate
	function automatic int eff_dim(input logic [DIM_W-1:0] d);
		return (d > MAX_DIM) ? MAX_DIM : int'(d);
	endfunction

	// round to nearest, ties upward, then clamp to 16 bits
	function automatic logic signed [DATA_W-1:0] round_saturate(input longint acc);
		longint r;
		r = (acc + 64'sd32768) >>> 16;
		if (r > 32767)
			r = 32767;
		else if (r < -32768)
			r = -32768;
		return DATA_W'(r);
	endfunction

	// one compute: every c element in row-major order, written back to the c store
	function automatic void gemm_predict();
		int                       m, n, k, lda, ldb, ai, bi, ci;
		longint                   alpha, beta, acc;
		logic signed [DATA_W-1:0] r;
		c_elem_t                  e;
		m     = eff_dim(cfg_shadow.rows_m);
		n     = eff_dim(cfg_shadow.cols_n);
		k     = eff_dim(cfg_shadow.inner_k);
		lda   = cfg_shadow.transpose_a ? m : k;
		ldb   = cfg_shadow.transpose_b ? k : n;
		alpha = longint'($signed(cfg_shadow.alpha_gain));
		beta  = longint'($signed(cfg_shadow.beta_gain));
		for (int i = 0; i < m; i++) begin
			for (int j = 0; j < n; j++) begin
				ci  = (i * n + j) % STORE_DEPTH;
				// old element brought up to the 24 fraction bits of the products
				acc = beta * longint'(c_mem[ci]) * 256;
				for (int t = 0; t < k; t++) begin
					ai  = (cfg_shadow.transpose_a ? t * lda + i : i * lda + t) % STORE_DEPTH;
					bi  = (cfg_shadow.transpose_b ? j * ldb + t : t * ldb + j) % STORE_DEPTH;
					acc += alpha * longint'(a_mem[ai]) * longint'(b_mem[bi]);
				end
				r         = round_saturate(acc);
				c_mem[ci] = r;
				e.pos     = ADDR_W'(ci);
				e.val     = r;
				e.last    = (i == m - 1) && (j == n - 1);
				c_expect_q.push_back(e);
			end
		end
	endfunction

	function automatic void gemm_apply(input action_t act, input logic [ADDR_W-1:0] pos,
			input logic signed [DATA_W-1:0] val);
		case (act)
			ACT_WR_A:    a_mem[pos] = val;
			ACT_WR_B:    b_mem[pos] = val;
			ACT_WR_C:    c_mem[pos] = val;
			ACT_COMPUTE: gemm_predict();
			default: ;
		endcase
	endfunction

	function automatic void shadow_write(input logic [REG_IDX_W-1:0] ri, input logic [31:0] d);
		case (ri)
			REG_TRANSPOSE_A: cfg_shadow.transpose_a = d[0];
			REG_TRANSPOSE_B: cfg_shadow.transpose_b = d[0];
			REG_ROWS_M:      cfg_shadow.rows_m      = d[DIM_W-1:0];
			REG_COLS_N:      cfg_shadow.cols_n      = d[DIM_W-1:0];
			REG_INNER_K:     cfg_shadow.inner_k     = d[DIM_W-1:0];
			REG_ALPHA_GAIN:  cfg_shadow.alpha_gain  = d[DATA_W-1:0];
			REG_BETA_GAIN:   cfg_shadow.beta_gain   = d[DATA_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic logic [31:0] shadow_read(input logic [REG_IDX_W-1:0] ri);
		case (ri)
			REG_TRANSPOSE_A: return {31'b0, cfg_shadow.transpose_a};
			REG_TRANSPOSE_B: return {31'b0, cfg_shadow.transpose_b};
			REG_ROWS_M:      return {28'b0, cfg_shadow.rows_m};
			REG_COLS_N:      return {28'b0, cfg_shadow.cols_n};
			REG_INNER_K:     return {28'b0, cfg_shadow.inner_k};
			REG_ALPHA_GAIN:  return {16'b0, cfg_shadow.alpha_gain};
			REG_BETA_GAIN:   return {16'b0, cfg_shadow.beta_gain};
			default:         return 32'b0;
		endcase
	endfunction

	// implemented bits of each register, compared on readback
	function automatic logic [31:0] reg_mask(input logic [REG_IDX_W-1:0] ri);
		case (ri)
			REG_TRANSPOSE_A, REG_TRANSPOSE_B:       return 32'h1;
			REG_ROWS_M, REG_COLS_N, REG_INNER_K:    return 32'hf;
			REG_ALPHA_GAIN, REG_BETA_GAIN:          return 32'hffff;
			default:                                return 32'h0;
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// random values
	// ------------------------------------------------------------------------

	// mostly small q8.8 numbers so that sums stay in range, now and then any pattern
	function automatic logic signed [DATA_W-1:0] rand_q88();
		if ($urandom_range(3) == 0)
			return DATA_W'($urandom);
		return DATA_W'($urandom_range(2047)) - 16'sd1024;
	endfunction

	// gain with unused upper bus bits randomised as well
	function automatic logic [31:0] rand_gain();
		logic [DATA_W-1:0] g;
		case ($urandom_range(4))
			0:       g = 16'h0100;
			1:       g = DATA_W'($urandom_range(1023)) - 16'd512;
			2:       g = DATA_W'($urandom);
			3:       g = $urandom_range(1) ? 16'h7fff : 16'h8000;
			default: g = 16'h0000;
		endcase
		return {16'($urandom), g};
	endfunction

	// small shapes mostly, the full four-bit range from time to time
	function automatic logic [31:0] rand_dim();
		if ($urandom_range(9) == 0)
			return {28'($urandom), 4'($urandom_range(15))};
		return 32'($urandom_range(1, 4));
	endfunction

	// ------------------------------------------------------------------------
	// bus drivers, all changes at the falling edge
	// ------------------------------------------------------------------------

	// setup then access phase, data taken at the edge that ends the access
	task automatic reg_access(input bit wr, input logic [REG_IDX_W-1:0] ri,
			input logic [31:0] d, output logic [31:0] rd);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {ri, 2'b00};
		pwdata  <= d;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		rd = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	task automatic check_register(input logic [REG_IDX_W-1:0] ri);
		logic [31:0] rd;
		reg_access(1'b0, ri, 32'b0, rd);
		if ((rd & reg_mask(ri)) != shadow_read(ri)) begin
			$error("register %0d readback: expected %h, actual %h", ri, shadow_read(ri),
				rd & reg_mask(ri));
			mismatch_count++;
		end
	endtask

	// registers change only with the block idle and every element received
	task automatic set_register(input logic [REG_IDX_W-1:0] ri, input logic [31:0] d);
		logic [31:0] rd;
		start <= 1'b0;
		while (c_expect_q.size() != 0 || busy)
			@(negedge clk);
		// a compute with no elements may still be finishing
		if (settle_needed) begin
			repeat (QUIET_CYCLES) @(negedge clk);
			settle_needed = 1'b0;
		end
		reg_access(1'b1, ri, d, rd);
		shadow_write(ri, d);
		if (reg_mask(ri) != 0)
			check_register(ri);
	endtask

	// one command transaction; returns at the next falling edge with start still high
	task automatic send_item(input action_t act, input logic [ADDR_W-1:0] pos,
			input logic signed [DATA_W-1:0] val);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start  <= 1'b1;
		action <= act;
		index  <= pos;
		value  <= val;
		do
			@(posedge clk);
		while (busy);
		gemm_apply(act, pos, val);
		if (act == ACT_COMPUTE)
			settle_needed = 1'b1;
		items_sent++;
		@(negedge clk);
	endtask

	// ------------------------------------------------------------------------
	// directed table
	// ------------------------------------------------------------------------

	function automatic void row_cfg(input logic [REG_IDX_W-1:0] ri, input logic [31:0] d);
		stim_row_t r;
		r.is_cfg    = 1'b1;
		r.reg_idx   = ri;
		r.reg_val   = d;
		r.act       = ACT_WR_A;
		r.pos       = '0;
		r.val       = '0;
		r.typed     = 1'b0;
		r.typed_val = '0;
		dir_rows.push_back(r);
	endfunction

	function automatic void row_item(input action_t act, input logic [ADDR_W-1:0] pos = '0,
			input logic signed [DATA_W-1:0] val = '0, input bit typed = 1'b0,
			input logic signed [DATA_W-1:0] typed_val = '0);
		stim_row_t r;
		r.is_cfg    = 1'b0;
		r.reg_idx   = '0;
		r.reg_val   = '0;
		r.act       = act;
		r.pos       = pos;
		r.val       = val;
		r.typed     = typed;
		r.typed_val = typed_val;
		dir_rows.push_back(r);
	endfunction

	function automatic void build_directed();
		// single element shape, answers readable by eye
		row_cfg(REG_ROWS_M, 32'd1);
		row_cfg(REG_COLS_N, 32'd1);
		row_cfg(REG_INNER_K, 32'd1);
		row_item(ACT_WR_A, 6'd0, 16'sh0100);
		row_item(ACT_WR_B, 6'd0, 16'sh7fff);
		row_item(ACT_COMPUTE, 6'd0, 16'sh0000, 1'b1, 16'sh7fff);
		row_item(ACT_WR_B, 6'd0, 16'sh8000);
		row_item(ACT_COMPUTE, 6'd0, 16'sh0000, 1'b1, 16'sh8000);
		// exact half, positive rounds up, negative rounds up to zero
		row_item(ACT_WR_A, 6'd0, 16'sh0001);
		row_item(ACT_WR_B, 6'd0, 16'sh0080);
		row_item(ACT_COMPUTE, 6'd0, 16'sh0000, 1'b1, 16'sh0001);
		row_item(ACT_WR_B, 6'd0, 16'shff80);
		row_item(ACT_COMPUTE, 6'd0, 16'sh0000, 1'b1, 16'sh0000);
		// saturation at both ends with extreme gains
		row_cfg(REG_ALPHA_GAIN, 32'h0000_7fff);
		row_item(ACT_WR_A, 6'd0, 16'sh7fff);
		row_item(ACT_WR_B, 6'd0, 16'sh7fff);
		row_item(ACT_COMPUTE, 6'd0, 16'sh0000, 1'b1, 16'sh7fff);
		row_cfg(REG_ALPHA_GAIN, 32'h0000_8000);
		row_item(ACT_WR_A, 6'd0, 16'sh8000);
		row_item(ACT_WR_B, 6'd0, 16'sh8000);
		row_item(ACT_COMPUTE, 6'd0, 16'sh0000, 1'b1, 16'sh8000);
		// old c element alone at unity beta
		row_cfg(REG_ALPHA_GAIN, 32'h0000_0000);
		row_cfg(REG_BETA_GAIN, 32'h0000_0100);
		row_item(ACT_WR_C, 6'd0, 16'sh1234);
		row_item(ACT_COMPUTE, 6'd0, 16'sh0000, 1'b1, 16'sh1234);
		// zero inner dimension leaves only the beta term
		row_cfg(REG_BETA_GAIN, 32'h0000_0000);
		row_cfg(REG_INNER_K, 32'd0);
		row_item(ACT_COMPUTE, 6'd0, 16'sh0000, 1'b1, 16'sh0000);
		// zero rows, then zero columns: nothing emitted
		row_cfg(REG_ROWS_M, 32'd0);
		row_item(ACT_COMPUTE);
		row_cfg(REG_ROWS_M, 32'd8);
		row_cfg(REG_COLS_N, 32'd0);
		row_item(ACT_COMPUTE);
		// oversized dimensions saturate, both operands transposed, most negative beta
		row_item(ACT_WR_A, 6'd63, 16'sh7fff);
		row_item(ACT_WR_C, 6'd63, 16'sh8000);
		row_cfg(REG_ROWS_M, 32'hffff_ffff);
		row_cfg(REG_COLS_N, 32'd15);
		row_cfg(REG_INNER_K, 32'd15);
		row_cfg(REG_TRANSPOSE_A, 32'd1);
		row_cfg(REG_TRANSPOSE_B, 32'hffff_ffff);
		row_cfg(REG_ALPHA_GAIN, 32'h0000_0100);
		row_cfg(REG_BETA_GAIN, 32'hffff_8000);
		row_item(ACT_COMPUTE);
		// write past the last register must leave everything as it was
		row_cfg(REG_UNUSED, 32'hffff_ffff);
		row_cfg(REG_TRANSPOSE_A, 32'd0);
		row_cfg(REG_ROWS_M, 32'd3);
		row_cfg(REG_COLS_N, 32'd5);
		row_cfg(REG_INNER_K, 32'd7);
		row_cfg(REG_ALPHA_GAIN, 32'h0000_0180);
		row_cfg(REG_BETA_GAIN, 32'h0000_7fff);
		row_item(ACT_COMPUTE);
	endfunction

	// ------------------------------------------------------------------------
	// result checker, sampled at the rising edge
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : result_check
		c_elem_t e;
		if (arst_n && valid) begin
			if (c_expect_q.size() == 0) begin
				$error("unexpected result transaction: out_index %0d out_value %0d",
					out_index, out_value);
				mismatch_count++;
			end else begin
				e = c_expect_q.pop_front();
				if (out_index !== e.pos) begin
					$error("out_index: expected %0d, actual %0d", e.pos, out_index);
					mismatch_count++;
				end
				if (out_value !== e.val) begin
					$error("out_value: expected %0d, actual %0d", e.val, out_value);
					mismatch_count++;
				end
				if (last !== e.last) begin
					$error("last: expected %0d, actual %0d", e.last, last);
					mismatch_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------
	initial begin : main_seq
		int      phase;
		int      batch;
		c_elem_t e;

		// register copy at its reset values
		cfg_shadow            = '0;
		cfg_shadow.rows_m     = RST_DIM;
		cfg_shadow.cols_n     = RST_DIM;
		cfg_shadow.inner_k    = RST_DIM;
		cfg_shadow.alpha_gain = RST_ALPHA;
		cfg_shadow.beta_gain  = RST_BETA;

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// registers must read back their reset values
		for (int ri = 0; ri <= REG_BETA_GAIN; ri++)
			check_register(REG_IDX_W'(ri));

		// the stores are undefined after reset, so fill every entry before any compute
		for (int p = 0; p < STORE_DEPTH; p++) begin
			send_item(ACT_WR_A, ADDR_W'(p), rand_q88());
			send_item(ACT_WR_B, ADDR_W'(p), rand_q88());
			send_item(ACT_WR_C, ADDR_W'(p), rand_q88());
		end

		// full 8x8x8 compute under reset settings
		send_item(ACT_COMPUTE, '0, '0);

		// directed corner cases; hand-worked answers replace the model's where given
		build_directed();
		foreach (dir_rows[r]) begin
			if (dir_rows[r].is_cfg) begin
				set_register(dir_rows[r].reg_idx, dir_rows[r].reg_val);
			end else begin
				send_item(dir_rows[r].act, dir_rows[r].pos, dir_rows[r].val);
				if (dir_rows[r].typed) begin
					e     = c_expect_q.pop_back();
					e.val = dir_rows[r].typed_val;
					c_expect_q.push_back(e);
				end
			end
		end

		// random phases: new settings, a burst of loads with computes mixed in,
		// always closed by a compute; idling rotates through none, heavy and light
		items_sent = 0;
		phase      = 0;
		while (items_sent < RANDOM_ITEMS) begin
			idle_pct = IDLE_NONE;
			set_register(REG_TRANSPOSE_A, $urandom);
			set_register(REG_TRANSPOSE_B, $urandom);
			set_register(REG_ROWS_M, rand_dim());
			set_register(REG_COLS_N, rand_dim());
			set_register(REG_INNER_K, rand_dim());
			set_register(REG_ALPHA_GAIN, rand_gain());
			set_register(REG_BETA_GAIN, rand_gain());
			case (phase % 3)
				0:       idle_pct = IDLE_NONE;
				1:       idle_pct = IDLE_HEAVY;
				default: idle_pct = IDLE_LIGHT;
			endcase
			batch = $urandom_range(8, 24);
			repeat (batch) begin
				if ($urandom_range(99) < 15)
					send_item(ACT_COMPUTE, ADDR_W'($urandom), rand_q88());
				else
					send_item(action_t'($urandom_range(2)), ADDR_W'($urandom), rand_q88());
			end
			send_item(ACT_COMPUTE, ADDR_W'($urandom), rand_q88());
			phase++;
		end

		// drain, then give a late or surplus element time to show
		start <= 1'b0;
		while (c_expect_q.size() != 0)
			@(negedge clk);
		repeat (QUIET_CYCLES) @(negedge clk);

		if (mismatch_count == 0)
			$display("[general_matrix_multiply_top] OK");
		else
			$display("[general_matrix_multiply_top] ERROR");
		$finish;
	end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/gmm_pkg.sv
hw/rtl/gmm_ram.sv
hw/rtl/gmm_mac.sv
hw/rtl/gmm_seq.sv
hw/rtl/general_matrix_multiply_top.sv
hw/rtl/gmm_checker.sv
tb/sv/general_matrix_multiply_top_tb.sv
